// ===== rtl/core/two_bit_nucleotide_kmer_store_top_macros.svh =====
// Assertion macros used by the k-mer store.
`ifndef TWO_BIT_NUCLEOTIDE_KMER_STORE_TOP_MACROS_SVH
`define TWO_BIT_NUCLEOTIDE_KMER_STORE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define TBNKS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("k-mer store: same-cycle check failed");
// Next-cycle implication.
`define TBNKS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("k-mer store: next-cycle check failed");
`else
`define TBNKS_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define TBNKS_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/tbnks_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the k-mer store.
package tbnks_pkg;

    // Store geometry.
    localparam int SEQ_CAPACITY   = 4096;
    localparam int BASES_PER_WORD = 16;
    localparam int MAX_SPAN       = 32;
    localparam int KMER_BASES     = 16;
    localparam int MASK_BITS      = 32;
    localparam int SPAN           = (MAX_SPAN < MASK_BITS) ? MAX_SPAN : MASK_BITS;
    localparam int WORD_W         = 2 * BASES_PER_WORD;
    localparam int STORE_WORDS    = SEQ_CAPACITY / BASES_PER_WORD;
    localparam int ADDR_W         = $clog2(STORE_WORDS);
    localparam int OFF_W          = $clog2(BASES_PER_WORD);
    localparam int LEN_W          = $clog2(SEQ_CAPACITY) + 1;

    // Field widths.
    localparam int POS_W    = 12;
    localparam int KLEN_W   = 5;
    localparam int CHAR_W   = 8;
    localparam int KMER_W   = 32;
    localparam int CNT_W    = 6;
    localparam int WLEN_W   = 6;
    localparam int CODE_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // Stream packing.
    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 2;

    // Query window: three store words, packed eight offsets at a time.
    localparam int WIN_WORDS = 3;
    localparam int WIN_W     = WIN_WORDS * WORD_W;
    localparam int RD_IDX_W  = 2;
    localparam int LANES     = 8;
    localparam int GROUPS    = SPAN / LANES;
    localparam int GRP_W     = $clog2(GROUPS);

    // Queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MASK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN_CODE = 2'd2;
    localparam logic [MASK_BITS-1:0] RST_WINDOW_MASK  = 32'h0000_FFFF;
    localparam logic [WLEN_W-1:0]    RST_WINDOW_LEN   = 6'd16;
    localparam logic [CODE_W-1:0]    RST_UNKNOWN_CODE = 2'd0;

    // Item kinds.
    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_CONTIG = 2'd2,
        KIND_MASKED = 2'd3
    } t_kind;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_FULL    = 2'd2,
        ST_RANGE   = 2'd3
    } t_status;

    // One classified word handed from the front to the back.
    typedef struct packed {
        t_kind                 kind;
        logic [CODE_W-1:0]     code;
        logic                  unknown;
        logic                  pre_bad;
        logic [POS_W-1:0]      base;
        logic [MASK_BITS-1:0]  sel;
    } t_op;

    // Queue fill status.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Ones in the n lowest bits, all ones from MASK_BITS up.
    function automatic logic [MASK_BITS-1:0] low_mask(input logic [WLEN_W-1:0] n);
        logic [MASK_BITS-1:0] m;
        m = '1;
        if (n < WLEN_W'(MASK_BITS)) begin
            m = ~({MASK_BITS{1'b1}} << n);
        end
        return m;
    endfunction

endpackage

// ===== rtl/core/tbnks_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module tbnks_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/tbnks_front.sv =====
`timescale 1ns / 1ps
// Front end: takes input words, holds configuration and classifies each word.
module tbnks_front import tbnks_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_kind                 i_kind,
    input  logic [CHAR_W-1:0]     i_nuc_char,
    input  logic [KLEN_W-1:0]     i_kmer_len,
    input  logic [POS_W-1:0]      i_position,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_q_stat               i_q,
    output logic                  o_push,
    output t_op                   o_op
);

    // Base codes.
    localparam logic [CODE_W-1:0] NUC_A = 2'd0;
    localparam logic [CODE_W-1:0] NUC_C = 2'd1;
    localparam logic [CODE_W-1:0] NUC_G = 2'd2;
    localparam logic [CODE_W-1:0] NUC_T = 2'd3;

    logic [MASK_BITS-1:0] r_window_mask;
    logic [WLEN_W-1:0]    r_window_len;
    logic [CODE_W-1:0]    r_unknown_code;

    logic [WLEN_W-1:0]    span_len;
    logic [CODE_W:0]      dec;
    t_op                  op;

    // Maps a character to {known, code}; unknown characters take the configured code.
    function automatic logic [CODE_W:0] nuc_decode(input logic [CHAR_W-1:0] ch,
                                                   input logic [CODE_W-1:0] unk);
        logic [CODE_W:0] r;
        case (ch) inside
            "A", "a", "U", "u": r = {1'b1, NUC_A};
            "C", "c":           r = {1'b1, NUC_C};
            "G", "g":           r = {1'b1, NUC_G};
            "T", "t":           r = {1'b1, NUC_T};
            default:            r = {1'b0, unk};
        endcase
        return r;
    endfunction

    // Configuration registers; writes are always taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_mask  <= RST_WINDOW_MASK;
            r_window_len   <= RST_WINDOW_LEN;
            r_unknown_code <= RST_UNKNOWN_CODE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WINDOW_MASK:  r_window_mask  <= i_cfg_data[MASK_BITS-1:0];
                CFG_WINDOW_LEN:   r_window_len   <= i_cfg_data[WLEN_W-1:0];
                CFG_UNKNOWN_CODE: r_unknown_code <= i_cfg_data[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // A masked query looks at no more offsets than the span allows.
    assign span_len = (r_window_len > WLEN_W'(SPAN)) ? WLEN_W'(SPAN) : r_window_len;
    assign dec      = nuc_decode(i_nuc_char, r_unknown_code);

    // Classify: both query kinds become a start base plus a selection mask.
    always_comb begin
        op         = '0;
        op.kind    = i_kind;
        op.code    = dec[CODE_W-1:0];
        op.unknown = !dec[CODE_W];
        op.base    = i_position;
        unique case (i_kind)
            KIND_CONTIG: begin
                op.base    = i_position + POS_W'(1) - POS_W'(i_kmer_len);
                op.pre_bad = (i_kmer_len == '0) || (i_kmer_len > KLEN_W'(KMER_BASES)) ||
                             (({1'b0, i_position} + (POS_W+1)'(1)) <
                              (POS_W+1)'(i_kmer_len));
                op.sel     = low_mask(WLEN_W'(i_kmer_len));
            end
            KIND_MASKED: begin
                op.sel = r_window_mask & low_mask(span_len);
            end
            default: ;
        endcase
    end

    // Hand the classified word to the queue whenever it has room.
    assign o_in_ready = !i_q.full;
    assign o_push     = i_in_valid && !i_q.full;
    assign o_op       = op;

endmodule

// ===== rtl/core/tbnks_fifo.sv =====
`timescale 1ns / 1ps
// Short queue of classified words between the front and the back.
module tbnks_fifo import tbnks_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_op     i_op,
    input  logic    i_pop,
    output t_op     o_head,
    output t_q_stat o_q
);

    t_op                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_q.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_q.empty = (r_count == '0);

endmodule

// ===== rtl/core/tbnks_back.sv =====
`timescale 1ns / 1ps
// Back end: owns the packed store, executes each word and holds the result register.
module tbnks_back import tbnks_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_op               i_head,
    input  t_q_stat           i_q,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [KMER_W-1:0] o_kmer,
    output logic [CNT_W-1:0]  o_base_count,
    output t_status           o_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_ALIGN,
        S_PACK,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [LEN_W-1:0]     r_seq_len;
    logic [WORD_W-1:0]    r_tail;
    logic [POS_W-1:0]     r_op_base;
    logic [MASK_BITS-1:0] r_sel;
    logic [RD_IDX_W-1:0]  r_rd_idx;
    logic [WIN_W-1:0]     r_win;
    logic [2*SPAN-1:0]    r_bases;
    logic [GRP_W-1:0]     r_grp;
    logic [KMER_W-1:0]    r_res_kmer;
    logic [CNT_W-1:0]     r_res_cnt;
    t_status              r_res_status;
    logic                 r_out_valid;
    logic [KMER_W-1:0]    r_out_kmer;
    logic [CNT_W-1:0]     r_out_cnt;
    t_status              r_out_status;

    logic [LEN_W:0]       avail;
    logic [WLEN_W-1:0]    avail_n;
    logic [MASK_BITS-1:0] allowed;
    logic                 q_bad;
    logic                 full;
    logic [OFF_W-1:0]     tail_off;
    logic [WORD_W-1:0]    tail_new;
    logic                 ram_wr_en;
    logic                 ram_rd_en;
    logic [ADDR_W-1:0]    ram_rd_addr;
    logic [WORD_W-1:0]    ram_rd_data;
    logic [WIN_W-1:0]     win_sh;
    logic [KMER_W-1:0]    acc_kmer;
    logic [CNT_W-1:0]     acc_cnt;

    // Range check of the queue head against the bases held now.
    always_comb begin
        avail   = {1'b0, r_seq_len} - (LEN_W+1)'(i_head.base);
        avail_n = (avail >= (LEN_W+1)'(MASK_BITS)) ? WLEN_W'(MASK_BITS)
                                                    : avail[WLEN_W-1:0];
        allowed = avail[LEN_W] ? '0 : low_mask(avail_n);
        q_bad   = |(i_head.sel & ~allowed);
    end

    // Append: the tail word starts fresh at a word boundary.
    assign full     = (r_seq_len == LEN_W'(SEQ_CAPACITY));
    assign tail_off = r_seq_len[OFF_W-1:0];
    assign tail_new = ((tail_off == '0) ? '0 : r_tail) |
                      (WORD_W'(i_head.code) << {tail_off, 1'b0});

    assign o_pop     = (r_state == S_IDLE) && !i_q.empty;
    assign ram_wr_en = o_pop && (i_head.kind == KIND_APPEND) && !full;

    // Window reads: three consecutive words from the start base's word.
    assign ram_rd_en   = (r_state == S_READ) && (r_rd_idx != RD_IDX_W'(WIN_WORDS));
    assign ram_rd_addr = r_op_base[OFF_W +: ADDR_W] + ADDR_W'(r_rd_idx);

    tbnks_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_seq_len[OFF_W +: ADDR_W]),
        .i_wr_data (tail_new),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Align the window so that offset zero of the query sits in the low bits.
    assign win_sh = r_win >> {r_op_base[OFF_W-1:0], 1'b0};

    // Pack one group of offsets: each selected base shifts in below the earlier ones.
    always_comb begin
        acc_kmer = r_res_kmer;
        acc_cnt  = r_res_cnt;
        for (int j = 0; j < LANES; j++) begin
            if (r_sel[j]) begin
                acc_kmer = {acc_kmer[KMER_W-3:0], r_bases[2*j +: 2]};
                acc_cnt  = acc_cnt + CNT_W'(1);
            end
        end
    end

    // Sequencer, store length and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seq_len   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The result register empties when taken, unless a new result refills it.
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q.empty) begin
                        r_op_base  <= i_head.base;
                        r_sel      <= i_head.sel;
                        r_res_kmer <= '0;
                        r_res_cnt  <= '0;
                        r_rd_idx   <= '0;
                        unique case (i_head.kind)
                            KIND_CLEAR: begin
                                r_seq_len    <= '0;
                                r_res_status <= ST_OK;
                                r_state      <= S_DONE;
                            end
                            KIND_APPEND: begin
                                r_state <= S_DONE;
                                if (full) begin
                                    r_res_status <= ST_FULL;
                                end else begin
                                    r_seq_len    <= r_seq_len + LEN_W'(1);
                                    r_tail       <= tail_new;
                                    r_res_status <= i_head.unknown ? ST_UNKNOWN : ST_OK;
                                end
                            end
                            KIND_CONTIG, KIND_MASKED: begin
                                if (i_head.pre_bad || q_bad) begin
                                    r_res_status <= ST_RANGE;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_res_status <= ST_OK;
                                    r_state      <= S_READ;
                                end
                            end
                            default: begin
                                r_res_status <= ST_OK;
                                r_state      <= S_DONE;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    if (r_rd_idx != '0) begin
                        r_win <= {ram_rd_data, r_win[WIN_W-1:WORD_W]};
                    end
                    r_rd_idx <= r_rd_idx + RD_IDX_W'(1);
                    if (r_rd_idx == RD_IDX_W'(WIN_WORDS)) begin
                        r_state <= S_ALIGN;
                    end
                end
                S_ALIGN: begin
                    r_bases <= win_sh[2*SPAN-1:0];
                    r_grp   <= '0;
                    r_state <= S_PACK;
                end
                S_PACK: begin
                    r_res_kmer <= acc_kmer;
                    r_res_cnt  <= acc_cnt;
                    r_bases    <= r_bases >> (2 * LANES);
                    r_sel      <= r_sel >> LANES;
                    r_grp      <= r_grp + GRP_W'(1);
                    if (r_grp == GRP_W'(GROUPS - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_kmer   <= r_res_kmer;
                        r_out_cnt    <= r_res_cnt;
                        r_out_status <= r_res_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kmer       = r_out_kmer;
    assign o_base_count = r_out_cnt;
    assign o_status     = r_out_status;

endmodule

// ===== rtl/core/two_bit_nucleotide_kmer_store_top.sv =====
`timescale 1ns / 1ps
// Top level of the two-bit nucleotide k-mer store.
//
// Channel   Direction  Handshake                        Payload
// s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tuser kind, tdata char/len/position
// m_axis    out        o_m_axis_tvalid/i_m_axis_tready  tuser status, tdata kmer/base_count
// cfg       in         i_cfg_valid/o_cfg_ready          i_cfg_index, i_cfg_data
//
// Clear and append go from idle straight to the done state of the back end, as does a query
// that fails its range check; any other query reads three window words through the single
// read port of the store memory, aligns them and passes them through the 8-lane packer.
// A two-word queue lets input words keep arriving while the back end works or the
// result register waits. Reset is synchronous; the store needs no clearing pass.
`include "two_bit_nucleotide_kmer_store_top_macros.svh"
module two_bit_nucleotide_kmer_store_top import tbnks_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [7:0] nuc_char, [12:8] kmer_len, [24:13] position, [31:25] zero
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [1:0] kind
    input  logic [IN_TUSER_W-1:0]  i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [31:0] kmer, [37:32] base_count, [39:38] zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // [1:0] status
    output logic [OUT_TUSER_W-1:0] o_m_axis_tuser,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_q_stat           q_stat;
    t_op               push_op;
    t_op               head_op;
    logic              push;
    logic              pop;
    logic [KMER_W-1:0] out_kmer;
    logic [CNT_W-1:0]  out_cnt;
    t_status           out_status;

    // Front: accept and classify.
    tbnks_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_kind      (t_kind'(i_s_axis_tuser[1:0])),
        .i_nuc_char  (i_s_axis_tdata[CHAR_W-1:0]),
        .i_kmer_len  (i_s_axis_tdata[CHAR_W +: KLEN_W]),
        .i_position  (i_s_axis_tdata[CHAR_W+KLEN_W +: POS_W]),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q         (q_stat),
        .o_push      (push),
        .o_op        (push_op)
    );

    // Queue between the two halves.
    tbnks_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_head  (head_op),
        .o_q     (q_stat)
    );

    // Back: store, queries and result register.
    tbnks_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_op),
        .i_q          (q_stat),
        .o_pop        (pop),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_kmer       (out_kmer),
        .o_base_count (out_cnt),
        .o_status     (out_status)
    );

    assign o_m_axis_tdata = {(OUT_TDATA_W - KMER_W - CNT_W)'(0), out_cnt, out_kmer};
    assign o_m_axis_tuser = out_status;

    // A failed item reports no bases.
    `TBNKS_ASSERT_IMP(a_fail_empty, i_clk, i_rst_n, o_m_axis_tvalid && (out_status != ST_OK) && (out_status != ST_UNKNOWN), (out_kmer == '0) && (out_cnt == '0))
    // No query shifts in more bases than the span.
    `TBNKS_ASSERT_IMP(a_cnt_span, i_clk, i_rst_n, o_m_axis_tvalid, out_cnt <= CNT_W'(SPAN))
    // A word pushed without a pop leaves the queue non-empty.
    `TBNKS_ASSERT_NXT(a_q_fill, i_clk, i_rst_n, push && !pop, !q_stat.empty)

endmodule
